// ===== hw/rtl/hltd_pkg.sv =====
// shared types and constants for the header/length/trailer deframer
package hltd_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned PosW   = 9;
	localparam int unsigned AddrW  = 5;
	localparam int unsigned DataW  = 32;

	localparam logic [ByteW-1:0] HdrFirstRst  = 8'hAE;
	localparam logic [ByteW-1:0] HdrSecondRst = 8'hEA;
	localparam logic [ByteW-1:0] TrlFirstRst  = 8'hEF;
	localparam logic [ByteW-1:0] TrlSecondRst = 8'hFE;
	localparam logic [PosW-1:0]  MaxLenRst    = 9'd100;

	typedef enum logic [2:0] {
		REG_HEADER_FIRST   = 3'd0,
		REG_HEADER_SECOND  = 3'd1,
		REG_TRAILER_FIRST  = 3'd2,
		REG_TRAILER_SECOND = 3'd3,
		REG_MAX_FRAME_LEN  = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IGNORED  = 3'd0,
		ST_HEADER   = 3'd1,
		ST_STORED   = 3'd2,
		ST_COMPLETE = 3'd3,
		ST_ABORTED  = 3'd4
	} status_t;

	typedef struct packed {
		logic [ByteW-1:0] header_first;
		logic [ByteW-1:0] header_second;
		logic [ByteW-1:0] trailer_first;
		logic [ByteW-1:0] trailer_second;
		logic [PosW-1:0]  max_frame_len;
	} cfg_t;

	typedef struct packed {
		status_t          status;
		logic [PosW-1:0]  position;
		logic [ByteW-1:0] data_byte;
		logic [PosW-1:0]  frame_length;
	} res_t;

endpackage

// ===== hw/rtl/header_length_trailer_deframer_top.sv =====
// Header/length/trailer deframer: one received byte per item, one result item per byte.
// A byte is taken into an input register, decided combinationally against the frame state and
// held in a result register, so a byte can be accepted every cycle while out_ready is high; a
// stall holds the result register. The throughput of one item per cycle is set by the frame
// state update (header match, length and trailer compares), which is combinational. in_ready
// follows out_ready combinationally through the two stages. The user must write configuration
// over the apb port only while no item is in flight; the block itself does not enforce it.
module header_length_trailer_deframer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hltd_pkg::AddrW-1:0]  paddr,
	input  logic [hltd_pkg::DataW-1:0]  pwdata,
	output logic [hltd_pkg::DataW-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [hltd_pkg::ByteW-1:0]  rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic [hltd_pkg::PosW-1:0]   position,
	output logic [hltd_pkg::ByteW-1:0]  data_byte,
	output logic [hltd_pkg::PosW-1:0]   frame_length
);
	import hltd_pkg::*;

	cfg_t             cfg;
	res_t             res;
	logic             v_s1;
	logic [ByteW-1:0] byte_s1;
	logic             v_s2;
	res_t             res_s2;
	logic             adv2;
	logic             take1;

	assign adv2     = !v_s2 || out_ready;
	assign take1    = v_s1 && adv2;
	assign in_ready = !v_s1 || adv2;

	hltd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	hltd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (take1),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
		if (take1) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = v_s2;
	assign status       = res_s2.status;
	assign position     = res_s2.position;
	assign data_byte    = res_s2.data_byte;
	assign frame_length = res_s2.frame_length;

`ifndef SYNTHESIS
	// a length is reported only with a completed frame
	a_len_only_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && res_s2.status != ST_COMPLETE) |-> (res_s2.frame_length == '0))
		else $error("frame_length set on a non-complete item");

	// a completed frame is at least four bytes long and its length is one more than its position
	a_complete_len: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && res_s2.status == ST_COMPLETE) |->
		(res_s2.frame_length == res_s2.position + PosW'(1) && res_s2.frame_length >= PosW'(4)))
		else $error("bad length on completed frame");

	// the second header byte always sits at position one
	a_header_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && res_s2.status == ST_HEADER) |-> (res_s2.position == PosW'(1)))
		else $error("header item at wrong position");

	// a stalled result holds while the next byte waits in the input register
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !out_ready) |=> $stable(res_s2))
		else $error("result changed during stall");
`endif

endmodule

// ===== hw/rtl/hltd_regs.sv =====
// apb configuration registers of the deframer
module hltd_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [hltd_pkg::AddrW-1:0]  paddr,
	input  logic [hltd_pkg::DataW-1:0]  pwdata,
	output logic [hltd_pkg::DataW-1:0]  prdata,
	output logic                        pready,
	output hltd_pkg::cfg_t              cfg
);
	import hltd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first   <= HdrFirstRst;
			cfg_q.header_second  <= HdrSecondRst;
			cfg_q.trailer_first  <= TrlFirstRst;
			cfg_q.trailer_second <= TrlSecondRst;
			cfg_q.max_frame_len  <= MaxLenRst;
		end else if (wr_en) begin
			case (idx)
				REG_HEADER_FIRST:   cfg_q.header_first   <= pwdata[ByteW-1:0];
				REG_HEADER_SECOND:  cfg_q.header_second  <= pwdata[ByteW-1:0];
				REG_TRAILER_FIRST:  cfg_q.trailer_first  <= pwdata[ByteW-1:0];
				REG_TRAILER_SECOND: cfg_q.trailer_second <= pwdata[ByteW-1:0];
				REG_MAX_FRAME_LEN:  cfg_q.max_frame_len  <= pwdata[PosW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_HEADER_FIRST:   prdata[ByteW-1:0] = cfg_q.header_first;
			REG_HEADER_SECOND:  prdata[ByteW-1:0] = cfg_q.header_second;
			REG_TRAILER_FIRST:  prdata[ByteW-1:0] = cfg_q.trailer_first;
			REG_TRAILER_SECOND: prdata[ByteW-1:0] = cfg_q.trailer_second;
			REG_MAX_FRAME_LEN:  prdata[PosW-1:0]  = cfg_q.max_frame_len;
			default:            prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/hltd_parse.sv =====
// frame tracking state and per-byte decision logic
module hltd_parse (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [hltd_pkg::ByteW-1:0]  rx_byte,
	input  hltd_pkg::cfg_t              cfg,
	output hltd_pkg::res_t              res
);
	import hltd_pkg::*;

	logic [ByteW-1:0] prev_byte_q;
	logic             in_frame_q;
	logic [PosW-1:0]  byte_count_q;
	logic [ByteW-1:0] length_field_q;

	logic             hdr;
	logic             framed;
	logic [PosW-1:0]  len2;
	logic [PosW-1:0]  len3;
	logic [PosW-1:0]  pos_inc;
	status_t          st;
	logic             nxt_in_frame;
	logic [PosW-1:0]  nxt_count;
	logic             load_len;

	assign hdr     = (rx_byte == cfg.header_second) && (prev_byte_q == cfg.header_first);
	assign framed  = in_frame_q && (byte_count_q >= PosW'(2));
	assign len2    = {1'b0, length_field_q} + PosW'(2);
	assign len3    = {1'b0, length_field_q} + PosW'(3);
	assign pos_inc = byte_count_q + PosW'(1);

	always_comb begin
		st           = ST_IGNORED;
		nxt_in_frame = 1'b0;
		nxt_count    = '0;
		load_len     = 1'b0;
		res.position     = '0;
		res.frame_length = '0;
		if (hdr) begin
			st           = ST_HEADER;
			nxt_in_frame = 1'b1;
			nxt_count    = PosW'(2);
			res.position = PosW'(1);
		end else if (framed) begin
			res.position = byte_count_q;
			if (byte_count_q >= cfg.max_frame_len) begin
				st = ST_ABORTED;
			end else if (byte_count_q == PosW'(2)) begin
				st       = ST_STORED;
				load_len = 1'b1;
			end else if (byte_count_q < len2) begin
				st = ST_STORED;
			end else if (byte_count_q == len2 && rx_byte == cfg.trailer_first) begin
				st = ST_STORED;
			end else if (byte_count_q == len3 && rx_byte == cfg.trailer_second) begin
				st               = ST_COMPLETE;
				res.frame_length = pos_inc;
			end else begin
				st = ST_ABORTED;
			end
			if (st == ST_STORED) begin
				nxt_in_frame = 1'b1;
				nxt_count    = pos_inc;
			end
		end
		res.status    = st;
		res.data_byte = rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_byte_q    <= '0;
			in_frame_q     <= 1'b0;
			byte_count_q   <= '0;
			length_field_q <= '0;
		end else if (en) begin
			prev_byte_q  <= rx_byte;
			in_frame_q   <= nxt_in_frame;
			byte_count_q <= nxt_count;
			if (load_len) begin
				length_field_q <= rx_byte;
			end
		end
	end

endmodule
